// ===== design/fcdbb_pkg.sv =====
// fcdbb_pkg: shared types for the fifo cache directory with byte budget
// no dependencies
package fcdbb_pkg;
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_RECORD = 1'b1;
    localparam int CFG_MAX_ENTRIES = 0;
    localparam int CFG_MAX_BYTES = 1;
endpackage

// ===== design/fifo_cache_directory_byte_budget_top.sv =====
// fifo_cache_directory_byte_budget_top: fifo replacement directory with byte budget
// entries in slot memories, insertion order kept as a shifted age list in a memory
// depends on fcdbb_pkg
//
//  channel  signals                                   direction
//  input    i_valid/o_stall, req_type key bytes       in
//  output   o_valid/i_stall, ok slot hit_bytes count  out
//  config   i_cfg_we, i_cfg_idx, i_cfg_data            in
//
// lookup: each slot walked is read, then compared, until a hit or the last slot
// record: each age position searched is read, then compared; then per drop a read, a
// clear and a shift of the age list, then the free scan walks slot by slot; the whole
// directory may be evicted for one record
// reset clears valid bits, count and total; no clearing pass
// input stalls while an item is in progress and while a result waits under output stall
module fifo_cache_directory_byte_budget_top
    import fcdbb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int KEY_BITS = 64,
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [63:0] i_entry_key,
    input  logic [31:0] i_entry_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [5:0]  o_slot,
    output logic [31:0] o_hit_bytes,
    output logic [6:0]  o_entry_count,
    output logic [31:0] o_total_bytes,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (SIZE_BITS < 32) ? SIZE_BITS : 32;
    localparam int KW = KEY_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LK_RD, ST_LK_CHK, ST_RC_RD, ST_RC_CHK, ST_EV_RD, ST_EV_DO,
        ST_SHIFT_RD, ST_SHIFT_WR, ST_FREE, ST_APPEND, ST_OUT
    } t_state;

    t_state           r_state;
    logic [6:0]       r_max_entries;
    logic [31:0]      r_max_bytes;
    logic [DEPTH-1:0] r_valid_bits;
    logic [CW-1:0]    r_count;
    logic [32:0]      r_total;
    logic             r_type;
    logic [KW-1:0]    r_key;
    logic [SW-1:0]    r_size;
    logic [CW-1:0]    r_idx;
    logic [AW-1:0]    r_cur_slot;
    logic             r_ovalid;
    logic             r_ok;
    logic [5:0]       r_slot;
    logic [31:0]      r_hb;

    logic [KW-1:0] key_mem [DEPTH];
    logic [SW-1:0] size_mem [DEPTH];
    logic [AW-1:0] age_mem [DEPTH];
    logic [KW-1:0] r_kq;
    logic [SW-1:0] r_sq;
    logic [AW-1:0] r_aq;

    logic          mem_we, age_we;
    logic [AW-1:0] mem_wa, mem_ra, age_wa, age_ra, age_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= r_key;
            size_mem[mem_wa] <= r_size;
        end
        if (age_we) age_mem[age_wa] <= age_wd;
        r_kq <= key_mem[mem_ra];
        r_sq <= size_mem[mem_ra];
        r_aq <= age_mem[age_ra];
    end

    logic [CW-1:0] limit;
    logic [33:0]   sum_next;
    logic          must_evict;
    always_comb begin
        if (r_max_entries == 7'd0) limit = CW'(1);
        else if (32'(r_max_entries) > 32'(DEPTH)) limit = CW'(DEPTH);
        else limit = CW'(r_max_entries);
        sum_next = {1'b0, r_total} + 34'(r_size);
        must_evict = (r_count != '0) &&
            ((r_count >= limit) || (sum_next > 34'(r_max_bytes)));
    end

    assign o_stall = (r_state != ST_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_ok = r_ok;
    assign o_slot = r_slot;
    assign o_hit_bytes = r_hb;
    assign o_entry_count = 7'(r_count);
    assign o_total_bytes = r_total[31:0];

    logic [AW-1:0] idx_a, idx_a1;
    assign idx_a = r_idx[AW-1:0];
    assign idx_a1 = AW'(r_idx + CW'(1));

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur_slot;
        mem_ra = idx_a;
        age_we = 1'b0;
        age_wa = idx_a;
        age_wd = r_aq;
        age_ra = idx_a;
        unique case (r_state)
            ST_IDLE: age_ra = '0;
            ST_RC_RD: begin
                mem_ra = r_aq;
                age_ra = '0;
            end
            ST_RC_CHK: age_ra = idx_a1;
            ST_EV_RD: mem_ra = r_aq;
            ST_SHIFT_RD: age_ra = (r_idx + CW'(1) >= r_count) ? '0 : idx_a1;
            ST_SHIFT_WR: begin
                age_we = 1'b1;
                age_ra = idx_a1;
            end
            ST_APPEND: begin
                mem_we = 1'b1;
                age_we = 1'b1;
                age_wa = AW'(r_count);
                age_wd = r_cur_slot;
            end
            default: ;
        endcase
    end

    // r_idx walks slots (lookup, free scan) or age positions (record, shift); r_aq is the registered age_mem read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max_entries <= 7'd64;
            r_max_bytes <= 32'd67108864;
            r_valid_bits <= '0;
            r_count <= '0;
            r_total <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'(CFG_MAX_ENTRIES)) r_max_entries <= i_cfg_data[6:0];
                else r_max_bytes <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_valid && !o_stall) begin
                    r_type <= i_req_type;
                    r_key <= i_entry_key[KW-1:0];
                    r_size <= i_entry_bytes[SW-1:0];
                    r_idx <= '0;
                    r_ok <= 1'b0;
                    r_slot <= '0;
                    r_hb <= '0;
                    if (i_req_type == REQ_LOOKUP) r_state <= ST_LK_RD;
                    else if (i_entry_key[KW-1:0] == '0 ||
                             32'(i_entry_bytes[SW-1:0]) > r_max_bytes)
                        r_state <= ST_OUT;
                    else r_state <= ST_RC_RD;
                end
                ST_LK_RD: r_state <= ST_LK_CHK;
                ST_LK_CHK: begin
                    if (r_valid_bits[idx_a] && r_kq == r_key) begin
                        r_ok <= 1'b1;
                        r_slot <= 6'(idx_a);
                        r_hb <= 32'(r_sq);
                        r_state <= ST_OUT;
                    end else if (r_idx == CW'(DEPTH - 1)) r_state <= ST_OUT;
                    else begin
                        r_idx <= r_idx + CW'(1);
                        r_state <= ST_LK_RD;
                    end
                end
                ST_RC_RD: begin
                    // r_aq now holds age_mem[r_idx]; r_kq next cycle
                    if (r_idx >= r_count) begin
                        r_idx <= '0;
                        r_state <= ST_EV_RD;
                    end else begin
                        r_cur_slot <= r_aq;
                        r_state <= ST_RC_CHK;
                    end
                end
                ST_RC_CHK: begin
                    if (r_valid_bits[r_cur_slot] && r_kq == r_key) begin
                        r_valid_bits[r_cur_slot] <= 1'b0;
                        r_total <= r_total - 33'(r_sq);
                        r_state <= ST_SHIFT_RD;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_state <= ST_RC_RD;
                    end
                end
                ST_EV_RD: begin
                    // r_aq is age_mem[0]
                    if (must_evict) begin
                        r_cur_slot <= r_aq;
                        r_state <= ST_EV_DO;
                    end else begin
                        r_idx <= '0;
                        r_state <= ST_FREE;
                    end
                end
                ST_EV_DO: begin
                    r_valid_bits[r_cur_slot] <= 1'b0;
                    r_total <= r_total - 33'(r_sq);
                    r_idx <= '0;
                    r_state <= ST_SHIFT_RD;
                end
                ST_SHIFT_RD: begin
                    if (r_idx + CW'(1) >= r_count) begin
                        r_count <= r_count - CW'(1);
                        r_idx <= '0;
                        r_state <= ST_EV_RD;
                    end else r_state <= ST_SHIFT_WR;
                end
                ST_SHIFT_WR: begin
                    r_idx <= r_idx + CW'(1);
                    r_state <= ST_SHIFT_RD;
                end
                ST_FREE: begin
                    if (sum_next > 34'(r_max_bytes) || r_count >= CW'(DEPTH))
                        r_state <= ST_OUT;
                    else if (!r_valid_bits[idx_a]) begin
                        r_cur_slot <= idx_a;
                        r_state <= ST_APPEND;
                    end else if (r_idx == CW'(DEPTH - 1)) r_state <= ST_OUT;
                    else r_idx <= r_idx + CW'(1);
                end
                ST_APPEND: begin
                    r_valid_bits[r_cur_slot] <= 1'b1;
                    r_count <= r_count + CW'(1);
                    r_total <= sum_next[32:0];
                    r_ok <= 1'b1;
                    r_slot <= 6'(r_cur_slot);
                    r_hb <= 32'(r_size);
                    r_state <= ST_OUT;
                end
                ST_OUT: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("live count above depth");
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok && r_type == REQ_RECORD) |-> o_entry_count != 7'd0)
        else $error("record ok with empty directory");
    a_valid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_valid_bits == '0))
        else $error("valid bits set with zero count");
`endif
endmodule
